>>> rtl/krhc_pkg.sv
// krhc_pkg: types, register codes and reset values for the request header check
// no dependencies; used by every other file of the block
package krhc_pkg;

  // field layout of the header
  localparam int unsigned HeaderBytes  = 14;
  localparam int unsigned SizeEnd      = 4;
  localparam int unsigned KeyEnd       = 6;
  localparam int unsigned VersionEnd   = 8;
  localparam int unsigned CorrEnd      = 12;
  localparam logic [31:0] MinSizeExcl  = 32'd4;
  localparam logic [15:0] NullClientLen = 16'hFFFF;
  localparam logic [15:0] CountMax     = 16'hFFFF;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_MESSAGE_SIZE     = 3'd0,
    REG_MAX_API_KEY          = 3'd1,
    REG_MAX_API_VERSION      = 3'd2,
    REG_MAX_CLIENT_ID_LENGTH = 3'd3
  } cfg_reg_t;

  localparam logic [31:0] RstMaxMessageSize    = 32'd104857600;
  localparam logic [14:0] RstMaxApiKey         = 15'd74;
  localparam logic [14:0] RstMaxApiVersion     = 15'd20;
  localparam logic [14:0] RstMaxClientIdLength = 15'd1024;

  // one collected header, handed from the front to the back
  typedef struct packed {
    logic [15:0] byte_count;
    logic [31:0] size_word;
    logic [15:0] key_word;
    logic [15:0] version_word;
    logic [31:0] correlation_word;
    logic [15:0] client_len_word;
  } hdr_rec_t;

  // queue depth between front and back
  localparam int unsigned QueueDepth = 2;

endpackage

>>> rtl/krhc_if.sv
// krhc_if: valid/ready channel interfaces for bytes, verdicts and register writes
// depends on krhc_pkg
interface krhc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface krhc_verdict_if;
  logic        valid;
  logic        ready;
  logic        is_request;
  logic [14:0] request_key;
  modport source (output valid, output is_request, output request_key, input ready);
  modport sink (input valid, input is_request, input request_key, output ready);
endinterface

interface krhc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [krhc_pkg::CfgIdxW-1:0]  index;
  logic [krhc_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/krhc_front.sv
// krhc_front: takes bytes, assembles the big-endian header fields and counts bytes
// depends on krhc_pkg and krhc_if; hands one header record per buffer to the queue
module krhc_front (
  input  logic                clk,
  input  logic                rst,
  krhc_byte_if.sink           bytes,
  output logic                push,
  output krhc_pkg::hdr_rec_t  rec,
  input  logic                queue_ready
);

  logic [15:0] byte_count;
  logic [31:0] size_word;
  logic [15:0] key_word;
  logic [15:0] version_word;
  logic [31:0] correlation_word;
  logic [15:0] client_len_word;
  logic        accept;

  assign bytes.ready = queue_ready;
  assign accept      = bytes.valid && bytes.ready;
  assign push        = accept && bytes.last_byte;

  // next field values with the current byte shifted in at its place
  always_comb begin
    rec.size_word        = size_word;
    rec.key_word         = key_word;
    rec.version_word     = version_word;
    rec.correlation_word = correlation_word;
    rec.client_len_word  = client_len_word;
    if (byte_count < 16'(krhc_pkg::SizeEnd)) begin
      rec.size_word = {size_word[23:0], bytes.data_byte};
    end else if (byte_count < 16'(krhc_pkg::KeyEnd)) begin
      rec.key_word = {key_word[7:0], bytes.data_byte};
    end else if (byte_count < 16'(krhc_pkg::VersionEnd)) begin
      rec.version_word = {version_word[7:0], bytes.data_byte};
    end else if (byte_count < 16'(krhc_pkg::CorrEnd)) begin
      rec.correlation_word = {correlation_word[23:0], bytes.data_byte};
    end else if (byte_count < 16'(krhc_pkg::HeaderBytes)) begin
      rec.client_len_word = {client_len_word[7:0], bytes.data_byte};
    end
    // saturating byte count
    rec.byte_count = (byte_count == krhc_pkg::CountMax) ? byte_count : byte_count + 16'd1;
  end

  // byte counter, cleared after the last byte of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= bytes.last_byte ? 16'd0 : rec.byte_count;
    end
  end

  // field registers; fields not fully received only matter for short buffers
  always_ff @(posedge clk) begin
    if (accept) begin
      size_word        <= rec.size_word;
      key_word         <= rec.key_word;
      version_word     <= rec.version_word;
      correlation_word <= rec.correlation_word;
      client_len_word  <= rec.client_len_word;
    end
  end

endmodule

>>> rtl/krhc_queue.sv
// krhc_queue: short queue of header records between front and back
// depends on krhc_pkg
module krhc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  krhc_pkg::hdr_rec_t push_rec,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output krhc_pkg::hdr_rec_t head
);

  localparam int unsigned PtrW = $clog2(krhc_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(krhc_pkg::QueueDepth + 1);

  krhc_pkg::hdr_rec_t entries [krhc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign not_full  = fill != CntW'(krhc_pkg::QueueDepth);
  assign not_empty = fill != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(krhc_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(krhc_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

>>> rtl/krhc_back.sv
// krhc_back: limit registers, verdict on one header record and the output register
// depends on krhc_pkg and krhc_if
module krhc_back (
  input  logic               clk,
  input  logic               rst,
  krhc_cfg_if.sink           cfg,
  input  logic               rec_valid,
  input  krhc_pkg::hdr_rec_t rec,
  output logic               pop,
  krhc_verdict_if.source     verdict
);

  logic [31:0] max_message_size;
  logic [14:0] max_api_key;
  logic [14:0] max_api_version;
  logic [14:0] max_client_id_length;

  logic        size_ok;
  logic        key_ok;
  logic        version_ok;
  logic        corr_ok;
  logic        clen_ok;
  logic        accepted;
  logic [16:0] need_count;

  // limit register writes; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_size     <= krhc_pkg::RstMaxMessageSize;
      max_api_key          <= krhc_pkg::RstMaxApiKey;
      max_api_version      <= krhc_pkg::RstMaxApiVersion;
      max_client_id_length <= krhc_pkg::RstMaxClientIdLength;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        krhc_pkg::REG_MAX_MESSAGE_SIZE:     max_message_size     <= cfg.data;
        krhc_pkg::REG_MAX_API_KEY:          max_api_key          <= cfg.data[14:0];
        krhc_pkg::REG_MAX_API_VERSION:      max_api_version      <= cfg.data[14:0];
        krhc_pkg::REG_MAX_CLIENT_ID_LENGTH: max_client_id_length <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // field checks; key, version, correlation id and client id length read as signed
  assign need_count = 17'(krhc_pkg::HeaderBytes) + {1'b0, rec.client_len_word};
  assign size_ok    = (rec.size_word > krhc_pkg::MinSizeExcl) &&
                      (rec.size_word <= max_message_size);
  assign key_ok     = !rec.key_word[15] && (rec.key_word[14:0] <= max_api_key);
  assign version_ok = !rec.version_word[15] && (rec.version_word[14:0] <= max_api_version);
  assign corr_ok    = !rec.correlation_word[31] && (rec.correlation_word != '0);
  assign clen_ok    = (rec.client_len_word == krhc_pkg::NullClientLen) ||
                      (!rec.client_len_word[15] &&
                       (rec.client_len_word[14:0] <= max_client_id_length) &&
                       ((rec.client_len_word == '0) ||
                        ({1'b0, rec.byte_count} >= need_count)));
  assign accepted   = (rec.byte_count >= 16'(krhc_pkg::HeaderBytes)) &&
                      size_ok && key_ok && version_ok && corr_ok && clen_ok;

  // output register takes a new verdict when empty or being drained
  assign pop = rec_valid && (!verdict.valid || verdict.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (pop) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict.is_request  <= accepted;
      verdict.request_key <= accepted ? rec.key_word[14:0] : 15'd0;
    end
  end

endmodule

>>> rtl/kafka_request_header_check_core.sv
// kafka_request_header_check_core: top level of the request header check
// depends on krhc_pkg, krhc_if, krhc_front, krhc_queue and krhc_back
//
//   channel  role   payload
//   bytes    sink   data_byte[7:0], last_byte
//   verdict  source is_request, request_key[14:0]
//   cfg      sink   index[2:0], data[31:0] (limit registers 0 to 3)
//
// one byte is taken per cycle while the queue has room; after the last byte the verdict
// passes through the record queue and the output register.
// reset clears the byte count, the queue and the output and loads default limits.
// a two-record queue absorbs output stalls; bytes stall only while it is full.
// register writes are always taken.
module kafka_request_header_check_core (
  input  logic           clk,
  input  logic           rst,
  krhc_byte_if.sink      bytes,
  krhc_verdict_if.source verdict,
  krhc_cfg_if.sink       cfg
);

  krhc_pkg::hdr_rec_t push_rec;
  krhc_pkg::hdr_rec_t head_rec;
  logic               push;
  logic               pop;
  logic               not_full;
  logic               not_empty;

  // byte collection
  krhc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .push        (push),
    .rec         (push_rec),
    .queue_ready (not_full)
  );

  // header record queue
  krhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head_rec)
  );

  // verdict and limits
  krhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (not_empty),
    .rec       (head_rec),
    .pop       (pop),
    .verdict   (verdict)
  );

endmodule

>>> verif/tb_kafka_request_header_check_core.sv
// tb_kafka_request_header_check_core: self-checking bench for the request header check
// depends on krhc_pkg, krhc_if and the kafka_request_header_check_core rtl
// a behavioural predictor scores every verdict; traffic runs under several limit settings
`timescale 1ns / 1ps

module tb_kafka_request_header_check_core;

  localparam int NumLimitRegs   = krhc_pkg::REG_MAX_CLIENT_ID_LENGTH + 1;
  localparam int IdxW           = krhc_pkg::CfgIdxW;
  localparam int HoldCycles     = 300;
  localparam int SettleCycles   = 8;
  localparam int DrainLimit     = 50000;
  localparam int PressureFrames = 40;
  localparam int NumDirRows     = 18;

  typedef struct packed {
    logic        is_request;
    logic [14:0] request_key;
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  logic clk;
  logic rst;

  krhc_byte_if    bytes_ch ();
  krhc_verdict_if verdict_ch ();
  krhc_cfg_if     cfg_ch ();

  kafka_request_header_check_core uut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .verdict (verdict_ch),
    .cfg     (cfg_ch)
  );

  // verdicts still owed by the block, oldest first
  verdict_t   verdicts_due[$];
  logic [7:0] frame_bytes[$];
  dir_row_t   dir_rows[NumDirRows];
  int         fault_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_request = 1'b0;

  // predictor copy of limits and header state
  logic [31:0] lim_size = krhc_pkg::RstMaxMessageSize;
  logic [14:0] lim_key  = krhc_pkg::RstMaxApiKey;
  logic [14:0] lim_ver  = krhc_pkg::RstMaxApiVersion;
  logic [14:0] lim_len  = krhc_pkg::RstMaxClientIdLength;
  logic [15:0] hdr_count = '0;
  logic [31:0] hdr_size  = '0;
  logic [15:0] hdr_key   = '0;
  logic [15:0] hdr_ver   = '0;
  logic [31:0] hdr_corr  = '0;
  logic [15:0] hdr_clen  = '0;

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // fold one byte into the header and judge it on the last byte
  function automatic void hdr_take(input logic [7:0] b, input logic fin,
                                   output logic due, output verdict_t v);
    logic ok;
    if (hdr_count < krhc_pkg::SizeEnd) begin
      hdr_size = {hdr_size[23:0], b};
    end else if (hdr_count < krhc_pkg::KeyEnd) begin
      hdr_key = {hdr_key[7:0], b};
    end else if (hdr_count < krhc_pkg::VersionEnd) begin
      hdr_ver = {hdr_ver[7:0], b};
    end else if (hdr_count < krhc_pkg::CorrEnd) begin
      hdr_corr = {hdr_corr[23:0], b};
    end else if (hdr_count < krhc_pkg::HeaderBytes) begin
      hdr_clen = {hdr_clen[7:0], b};
    end
    if (hdr_count != krhc_pkg::CountMax) hdr_count = hdr_count + 16'd1;
    due = fin;
    v = '0;
    if (fin) begin
      ok = 1'b1;
      if (hdr_count < krhc_pkg::HeaderBytes) ok = 1'b0;
      if (hdr_size <= krhc_pkg::MinSizeExcl || hdr_size > lim_size) ok = 1'b0;
      if (hdr_key[15] || hdr_key > {1'b0, lim_key}) ok = 1'b0;
      if (hdr_ver[15] || hdr_ver > {1'b0, lim_ver}) ok = 1'b0;
      if (hdr_corr[31] || hdr_corr == '0) ok = 1'b0;
      // a null client id length skips the length checks
      if (hdr_clen != krhc_pkg::NullClientLen) begin
        if (hdr_clen[15] || hdr_clen > {1'b0, lim_len}) ok = 1'b0;
        if (hdr_clen != '0 && 32'(hdr_count) < krhc_pkg::HeaderBytes + 32'(hdr_clen)) ok = 1'b0;
      end
      if (ok) v = '{is_request: 1'b1, request_key: hdr_key[14:0]};
      hdr_count = '0;
      hdr_size  = '0;
      hdr_key   = '0;
      hdr_ver   = '0;
      hdr_corr  = '0;
      hdr_clen  = '0;
    end
  endfunction

  // key or version value around its limit
  function automatic logic [15:0] pick_field16(input logic [14:0] lim);
    case ($urandom_range(5))
      0:       return '0;
      1:       return {1'b0, lim};
      2:       return {1'b0, lim} + 16'd1;
      3:       return {1'b1, 15'($urandom)};
      4:       return 16'($urandom);
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  // lay out a buffer: the 14 header bytes (cut short if len is under 14), then random payload
  function automatic void make_frame(input logic [31:0] size, input logic [15:0] key,
                                     input logic [15:0] ver, input logic [31:0] corr,
                                     input logic [15:0] clen, input int len);
    logic [111:0] head;
    head = {size, key, ver, corr, clen};
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      frame_bytes.push_back(i < krhc_pkg::HeaderBytes ? head[111 - 8 * i -: 8] : 8'($urandom));
    end
  endfunction

  // offer one byte request, wait for it to be taken, then predict
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input verdict_t typed_want);
    logic     due;
    verdict_t got;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    bytes_ch.data_byte = b;
    bytes_ch.last_byte = fin;
    bytes_ch.valid = 1'b1;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    hdr_take(b, fin, due, got);
    if (due) verdicts_due.push_back(typed ? typed_want : got);
    @(negedge clk);
    bytes_ch.valid = 1'b0;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  // hold the sender until every owed verdict is in, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    while (verdicts_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write request
  task automatic write_limit(input logic [krhc_pkg::CfgIdxW-1:0] idx,
                             input logic [krhc_pkg::CfgDataW-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      krhc_pkg::REG_MAX_MESSAGE_SIZE:     lim_size = value;
      krhc_pkg::REG_MAX_API_KEY:          lim_key = value[14:0];
      krhc_pkg::REG_MAX_API_VERSION:      lim_ver = value[14:0];
      krhc_pkg::REG_MAX_CLIENT_ID_LENGTH: lim_len = value[14:0];
      default: ; // unused index, ignored by the block
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // new limit set once idle; upper data bits of the 15-bit registers are junk
  task automatic apply_limits(input logic [31:0] size, input logic [14:0] key,
                              input logic [14:0] ver, input logic [14:0] len);
    settle();
    write_limit(IdxW'($urandom_range(NumLimitRegs, (1 << IdxW) - 1)), $urandom);
    write_limit(krhc_pkg::REG_MAX_MESSAGE_SIZE, size);
    write_limit(krhc_pkg::REG_MAX_API_KEY, {17'($urandom), key});
    write_limit(krhc_pkg::REG_MAX_API_VERSION, {17'($urandom), ver});
    write_limit(krhc_pkg::REG_MAX_CLIENT_ID_LENGTH, {17'($urandom), len});
  endtask

  // random buffers, mostly headers with fields near the limits
  task automatic run_traffic(input int budget);
    int          sent;
    int          need;
    int          len;
    logic [31:0] size;
    logic [31:0] corr;
    logic [15:0] key;
    logic [15:0] ver;
    logic [15:0] clen;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(5))
        0:       size = $urandom_range(0, krhc_pkg::MinSizeExcl);
        1:       size = lim_size;
        2:       size = lim_size + 32'd1;
        3:       size = $urandom;
        default: size = $urandom_range(krhc_pkg::MinSizeExcl + 1, lim_size);
      endcase
      key = pick_field16(lim_key);
      ver = pick_field16(lim_ver);
      case ($urandom_range(6))
        0:       corr = '0;
        1:       corr = 32'd1;
        2:       corr = 32'h7FFF_FFFF;
        3:       corr = 32'h8000_0000;
        4:       corr = $urandom;
        default: corr = {1'b0, 31'($urandom)};
      endcase
      case ($urandom_range(8))
        0:       clen = krhc_pkg::NullClientLen;
        1:       clen = '0;
        2:       clen = {1'b0, lim_len};
        3:       clen = {1'b0, lim_len} + 16'd1;
        4:       clen = {1'b1, 15'($urandom)};
        5:       clen = 16'($urandom);
        default: clen = 16'($urandom_range(0, lim_len < 15'd12 ? lim_len : 15'd12));
      endcase
      // length around what the client id needs; long ones only now and then
      need = krhc_pkg::HeaderBytes;
      if (!clen[15]) need = krhc_pkg::HeaderBytes + clen;
      if (need <= 60 || ($urandom_range(15) == 0 && need <= 1200)) begin
        case ($urandom_range(3))
          0:       len = need - 1;
          3:       len = need + $urandom_range(1, 6);
          default: len = need;
        endcase
      end else begin
        len = $urandom_range(krhc_pkg::HeaderBytes, 40);
      end
      case ($urandom_range(9))
        0:       make_frame(size, key, ver, corr, clen,
                            $urandom_range(1, krhc_pkg::HeaderBytes - 1));
        1:       make_frame($urandom, 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                            $urandom_range(1, 24));
        default: make_frame(size, key, ver, corr, clen, len);
      endcase
      send_frame();
      sent += frame_bytes.size();
    end
  endtask

  // verdict receiver: random stalls, plus a long hold-off on request
  initial begin : verdict_sink
    int hold_left;
    hold_left = 0;
    verdict_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        verdict_ch.ready = 1'b0;
        hold_left--;
      end else begin
        verdict_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // score each verdict request against the oldest one owed
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none owed: is_request=%0b request_key=%0d",
                 $time, verdict_ch.is_request, verdict_ch.request_key);
        fault_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (verdict_ch.is_request !== want.is_request) begin
          $display("%0t: is_request expected %0b, got %0b",
                   $time, want.is_request, verdict_ch.is_request);
          fault_count++;
        end
        if (verdict_ch.request_key !== want.request_key) begin
          $display("%0t: request_key expected %0d, got %0d",
                   $time, want.request_key, verdict_ch.request_key);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    bytes_ch.valid = 1'b0;
    bytes_ch.data_byte = '0;
    bytes_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst = 1'b1;

    // one-byte buffer, a header right on the default limits, a short buffer, then a one-byte buffer
    dir_rows = '{
      '{8'hFF, 1'b1, 1'b1, '{1'b0, 15'd0}},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h05, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h4A, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h14, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b1, 1'b1, '{1'b1, 15'd74}},
      '{8'h12, 1'b0, 1'b0, '0}, '{8'h34, 1'b1, 1'b1, '{1'b0, 15'd0}},
      '{8'h00, 1'b1, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // defaults: directed rows, one buffer with payload after the header, then random traffic
    for (int i = 0; i < NumDirRows; i++) begin
      push_byte(dir_rows[i].data_byte, dir_rows[i].last_byte, dir_rows[i].typed,
                dir_rows[i].want);
    end
    make_frame($urandom_range(krhc_pkg::MinSizeExcl + 1, lim_size),
               16'($urandom_range(0, lim_key)), 16'($urandom_range(0, lim_ver)),
               $urandom_range(1, 32'h7FFF_FFFF), 16'($urandom_range(0, 48)),
               $urandom_range(64, 96));
    send_frame();
    run_traffic(280);

    // widest limits, sender mostly idle
    apply_limits(32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_idle_pct = 80;
    run_traffic(300);

    // narrowest legal limits, receiver mostly stalled
    apply_limits(krhc_pkg::MinSizeExcl + 1, '0, '0, '0);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    run_traffic(300);

    // size limit too tight for anything, light idling on both sides
    apply_limits($urandom_range(0, krhc_pkg::MinSizeExcl), 15'($urandom), 15'($urandom),
                 15'($urandom_range(0, 40)));
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_traffic(200);

    // random limits; receiver holds off while short buffers pile up
    apply_limits($urandom, 15'($urandom_range(0, 100)), 15'($urandom_range(0, 30)),
                 15'($urandom_range(0, 48)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    repeat (PressureFrames) begin
      make_frame($urandom, 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                 $urandom_range(1, 3));
      send_frame();
    end
    run_traffic(300);

    // back to the reset values
    apply_limits(krhc_pkg::RstMaxMessageSize, krhc_pkg::RstMaxApiKey,
                 krhc_pkg::RstMaxApiVersion, krhc_pkg::RstMaxClientIdLength);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_traffic(300);

    settle();
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/krhc_pkg.sv
rtl/krhc_if.sv
rtl/krhc_front.sv
rtl/krhc_queue.sv
rtl/krhc_back.sv
rtl/kafka_request_header_check_core.sv
verif/tb_kafka_request_header_check_core.sv
